@@ hdl/jpts_pkg.sv @@
// Shared types and constants for the jet patch trigger sum block.
`timescale 1ns / 1ps

package jpts_pkg;

  localparam int CHAN_W     = 16;
  localparam int NUM_CHAN   = 6;
  localparam int FIELD_W    = 6;
  localparam int HIGH_LSB   = 6;
  localparam int HT_LSB     = 12;
  localparam int HT_W       = 2;
  localparam int SUM_W      = 8;
  localparam int THR_W      = 8;
  localparam int LEVEL_W    = 2;
  localparam int PATCH_W    = 2;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [THR_W-1:0] THR_RESET = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATCH_THR_0 = 2'd0,
    REG_PATCH_THR_1 = 2'd1,
    REG_PATCH_THR_2 = 2'd2,
    REG_DIJET_THR   = 2'd3
  } reg_index_t;

  // Patch identifiers as reported in selected_patch.
  localparam logic [PATCH_W-1:0] PATCH_A = 2'd1;
  localparam logic [PATCH_W-1:0] PATCH_B = 2'd2;
  localparam logic [PATCH_W-1:0] PATCH_C = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] patch_thr_0;
    logic [THR_W-1:0] patch_thr_1;
    logic [THR_W-1:0] patch_thr_2;
    logic [THR_W-1:0] dijet_thr;
  } thr_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_c;
    logic [SUM_W-1:0]   sum_b;
    logic [SUM_W-1:0]   sum_a;
    logic [HT_W-1:0]    high_tower_bits;
    logic [PATCH_W-1:0] selected_patch;
    logic [FIELD_W-1:0] selected_low_sum;
    logic               dijet_c;
    logic               dijet_b;
    logic               dijet_a;
    logic [LEVEL_W-1:0] threshold_level;
  } result_t;

endpackage

@@ hdl/jet_patch_trigger_sum.sv @@
// Top level of the jet patch trigger sum block: registers, handshake and packing.
`timescale 1ns / 1ps

// Takes one word of six 16-bit trigger channels per clock and returns one
// result word for each, in order, at a sustained rate of one word per cycle
// while m_tready stays high. A word accepted into the input register passes
// through the combinational patch logic and is loaded into the result
// register once that register is empty or its word is being taken; m_tvalid
// then rises, and the result is taken at an edge where m_tready is high. Each
// register stage holds one word, so up to two words are in flight. s_tready
// stays high while a finished result waits with the input register empty,
// and drops once both registers hold words and m_tready is low.
// The four thresholds reset to 255 and are written through cfg_we, cfg_index
// and cfg_data; write them only while no word is in flight.

module jet_patch_trigger_sum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // channel_0 .. channel_5, 16 bits each, channel_0 lowest
  input  logic [jpts_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // threshold_level[1:0], dijet_a, dijet_b, dijet_c, selected_low_sum[5:0],
  // selected_patch[1:0], high_tower_bits[1:0], sum_a, sum_b, sum_c, zero pad
  output logic [jpts_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [jpts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jpts_pkg::THR_W-1:0]       cfg_data
);

  jpts_pkg::thr_t                 thr;
  logic                           in_valid;
  logic [jpts_pkg::IN_DATA_W-1:0] in_data;
  logic                           out_valid;
  logic [jpts_pkg::OUT_DATA_W-1:0] out_data;
  jpts_pkg::result_t              result;
  logic                           out_load;
  logic                           in_load;

  assign out_load = !out_valid || m_tready;
  assign in_load  = !in_valid || out_load;
  assign s_tready = in_load;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.patch_thr_0 <= jpts_pkg::THR_RESET;
      thr.patch_thr_1 <= jpts_pkg::THR_RESET;
      thr.patch_thr_2 <= jpts_pkg::THR_RESET;
      thr.dijet_thr   <= jpts_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (jpts_pkg::reg_index_t'(cfg_index))
        jpts_pkg::REG_PATCH_THR_0: thr.patch_thr_0 <= cfg_data;
        jpts_pkg::REG_PATCH_THR_1: thr.patch_thr_1 <= cfg_data;
        jpts_pkg::REG_PATCH_THR_2: thr.patch_thr_2 <= cfg_data;
        jpts_pkg::REG_DIJET_THR:   thr.dijet_thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid <= s_tvalid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_tvalid) begin
      in_data <= s_tdata;
    end
    if (out_load && in_valid) begin
      out_data <= {1'b0, result};
    end
  end

  jpts_patch_logic u_patch_logic (
    .channels (in_data),
    .thr      (thr),
    .result   (result)
  );

endmodule

@@ hdl/jpts_patch_logic.sv @@
// Patch sums, threshold compares, low-sum selection and high-tower OR for one word.
`timescale 1ns / 1ps

module jpts_patch_logic (
  input  logic [jpts_pkg::IN_DATA_W-1:0] channels,
  input  jpts_pkg::thr_t                 thr,
  output jpts_pkg::result_t              result
);

  logic [jpts_pkg::CHAN_W-1:0]  chan [jpts_pkg::NUM_CHAN];
  logic [jpts_pkg::FIELD_W-1:0] la, lb, lc;
  logic [jpts_pkg::SUM_W-1:0]   sa, sb, sc;
  logic                         over_0, over_1, over_2;
  logic [jpts_pkg::HT_W-1:0]    ht;

  always_comb begin
    for (int i = 0; i < jpts_pkg::NUM_CHAN; i++) begin
      chan[i] = channels[i*jpts_pkg::CHAN_W +: jpts_pkg::CHAN_W];
    end
  end

  assign la = chan[0][jpts_pkg::FIELD_W-1:0];
  assign lb = chan[3][jpts_pkg::FIELD_W-1:0];
  assign lc = chan[4][jpts_pkg::FIELD_W-1:0];

  assign sa = {2'b00, la}
            + {2'b00, chan[0][jpts_pkg::HIGH_LSB +: jpts_pkg::FIELD_W]}
            + {2'b00, chan[1][jpts_pkg::FIELD_W-1:0]};
  assign sb = {2'b00, lb}
            + {2'b00, chan[3][jpts_pkg::HIGH_LSB +: jpts_pkg::FIELD_W]}
            + {2'b00, chan[2][jpts_pkg::FIELD_W-1:0]};
  assign sc = {2'b00, lc}
            + {2'b00, chan[4][jpts_pkg::HIGH_LSB +: jpts_pkg::FIELD_W]}
            + {2'b00, chan[5][jpts_pkg::FIELD_W-1:0]};

  assign over_0 = (sa > thr.patch_thr_0) || (sb > thr.patch_thr_0) || (sc > thr.patch_thr_0);
  assign over_1 = (sa > thr.patch_thr_1) || (sb > thr.patch_thr_1) || (sc > thr.patch_thr_1);
  assign over_2 = (sa > thr.patch_thr_2) || (sb > thr.patch_thr_2) || (sc > thr.patch_thr_2);

  always_comb begin
    ht = '0;
    for (int i = 0; i < jpts_pkg::NUM_CHAN; i++) begin
      ht = ht | chan[i][jpts_pkg::HT_LSB +: jpts_pkg::HT_W];
    end
  end

  always_comb begin
    result.threshold_level = {1'b0, over_0} + {1'b0, over_1} + {1'b0, over_2};
    result.dijet_a         = sa > thr.dijet_thr;
    result.dijet_b         = sb > thr.dijet_thr;
    result.dijet_c         = sc > thr.dijet_thr;
    result.high_tower_bits = ht;
    result.sum_a           = sa;
    result.sum_b           = sb;
    result.sum_c           = sc;
    // Each patch wins only if it beats the next one round the ring and is not
    // beaten by the previous one; three equal sums fall back to patch A.
    // The fields are six bits wide, so the selected sum never needs saturation.
    if (la > lb && !(lc > la)) begin
      result.selected_patch   = jpts_pkg::PATCH_A;
      result.selected_low_sum = la;
    end else if (lb > lc && !(la > lb)) begin
      result.selected_patch   = jpts_pkg::PATCH_B;
      result.selected_low_sum = lb;
    end else if (lc > la && !(lb > lc)) begin
      result.selected_patch   = jpts_pkg::PATCH_C;
      result.selected_low_sum = lc;
    end else begin
      result.selected_patch   = jpts_pkg::PATCH_A;
      result.selected_low_sum = la;
    end
  end

endmodule

@@ hdl/jpts_checker.sv @@
// Port-level checks for the jet patch trigger sum block, bound to the top level.
`timescale 1ns / 1ps

module jpts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [jpts_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word must hold.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A word accepted while the output side then takes results shows up on the output.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
    else $error("accepted word did not reach the output");

  // The selected patch is always one of A, B or C.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:11] != 2'd0)
    else $error("selected patch code is zero");

  // The low-eta sum is part of its patch sum, so patch A bounds it when chosen.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12:11] == jpts_pkg::PATCH_A |->
      m_tdata[22:15] >= {2'b00, m_tdata[10:5]})
    else $error("selected low sum exceeds patch A sum");

  // The padding bit stays zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[39])
    else $error("result padding bit set");

endmodule

bind jet_patch_trigger_sum jpts_checker u_jpts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
